// ----- hw/rtl/dstk_pkg.sv -----
// ----------------------------------------------------------------------------
// dstk_pkg
// shared types and constants for the data stack: default depth, word width, operation and error codes
// ----------------------------------------------------------------------------
package dstk_pkg;

   // default number of entries the stack holds
   localparam int unsigned STK_DEPTH = 256;

   // width of one stack word
   localparam int unsigned DATA_W = 32;

   // operation codes
   typedef enum logic [2:0] {
      FN_CLEAR   = 3'd0,
      FN_PUSH    = 3'd1,
      FN_DUP     = 3'd2,
      FN_SWAP    = 3'd3,
      FN_DISCARD = 3'd4,
      FN_COPY    = 3'd5,
      FN_SLIDE   = 3'd6,
      FN_POP     = 3'd7
   } func_type;

   // result codes
   typedef enum logic [2:0] {
      ERR_OK    = 3'd0,
      ERR_FULL  = 3'd1,
      ERR_EMPTY = 3'd2,
      ERR_FEW   = 3'd3,
      ERR_INDEX = 3'd4
   } err_type;

endpackage

// ----- hw/rtl/data_stack_with_dup_swap_copy_slide.sv -----
// ----------------------------------------------------------------------------
// data_stack_with_dup_swap_copy_slide
// data stack for a stack-machine interpreter: clear, push, dup, swap,
// discard, copy, slide and pop, one operation per beat
// ----------------------------------------------------------------------------
// usage
//   req channel: one beat carries an operation code (req_func) and a signed
//   operand (push value, 1-based copy position from the bottom, or slide
//   count). a beat is taken when req_valid is high and req_stall is low.
//   rsp channel: every request beat returns exactly one rsp beat with the
//   popped value (zero unless a pop succeeded), an error code and the depth
//   after the operation. the receiver holds a beat by raising rsp_stall.
// pipeline
//   the request is registered in the request stage at the accepting edge
//   and executed once the response stage is empty or handing its beat on;
//   the response is registered at the end of the executing cycle. a new
//   beat is taken every cycle while rsp_stall holds no response; the rate
//   is set by the update of the top register and the one-write, two-read stack memory.
// stalls
//   while rsp_stall holds a response, the request stage keeps its beat and
//   req_stall rises once that stage is occupied; nothing is lost.
// reset
//   synchronous, active high. the depth returns to zero and both stages
//   empty; the stack memory is not cleared, as no entry is read before it
//   has been written.
// ----------------------------------------------------------------------------
module data_stack_with_dup_swap_copy_slide
   import dstk_pkg::*;
#(
   parameter int unsigned DEPTH = STK_DEPTH,
   localparam int unsigned CW   = $clog2(DEPTH + 1),
   localparam int unsigned AW   = $clog2(DEPTH)
) (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [2:0]               req_func,
   input  logic signed [DATA_W-1:0] req_operand,
   // response channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_popped,
   output logic [2:0]               rsp_error,
   output logic [CW-1:0]            rsp_depth
);

   // the top of stack lives in a register; the memory holds the entries below
   localparam int unsigned MEM_WORDS = 2 ** AW;

   logic [DATA_W-1:0] mem [0:MEM_WORDS-1];

   // request stage
   logic                     s1_valid_ff;
   func_type                 s1_func_ff;
   logic signed [DATA_W-1:0] s1_operand_ff;

   // stack state
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [DATA_W-1:0] top_ff, top_in;

   // memory ports
   logic              mem_we;
   logic              wr_req;
   logic [AW-1:0]     wr_addr;
   logic [DATA_W-1:0] wr_data;
   logic [AW-1:0]     nos_addr;
   logic [AW-1:0]     cp_addr;
   logic [DATA_W-1:0] nos_rd_ff, cp_rd_ff;

   // write-through bypass for reads that hit the word written at the same edge
   logic              nos_hit_ff, cp_hit_ff;
   logic [DATA_W-1:0] wd_ff, cp_byp_ff;
   logic [DATA_W-1:0] nos, cp_val;

   // response stage
   logic              rsp_valid_ff;
   logic [DATA_W-1:0] popped_ff;
   err_type           error_ff;
   logic [CW-1:0]     depth_ff;

   // execute results
   err_type           err;
   logic [DATA_W-1:0] popped;
   logic [CW-1:0]     cnt_m1, cnt_m2;
   logic              full, empty;
   logic              copy_ok;
   logic              req_accept, exec;

   // handshake
   assign exec       = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !exec;
   assign req_accept = req_valid && !req_stall;

   assign cnt_m1 = cnt_ff - CW'(1);
   assign cnt_m2 = cnt_ff - CW'(2);
   assign full   = (cnt_ff >= CW'(DEPTH));
   assign empty  = (cnt_ff == '0);

   // second entry from the top and the copy source, bypass applied
   assign nos    = nos_hit_ff ? wd_ff : nos_rd_ff;
   assign cp_val = cp_hit_ff ? cp_byp_ff : cp_rd_ff;

   // copy position must lie in 1 .. depth
   assign copy_ok = !s1_operand_ff[DATA_W-1] && (s1_operand_ff != '0)
                    && ($unsigned(s1_operand_ff) <= DATA_W'(cnt_ff));

   // one operation: state update, memory write and response
   always_comb begin
      err     = ERR_OK;
      cnt_in  = cnt_ff;
      top_in  = top_ff;
      popped  = '0;
      wr_req  = 1'b0;
      wr_addr = cnt_m1[AW-1:0];
      wr_data = top_ff;
      unique case (s1_func_ff)
         FN_CLEAR: begin
            cnt_in = '0;
         end
         FN_PUSH: begin
            if (full) begin
               err = ERR_FULL;
            end else begin
               // old top sinks into the memory
               wr_req = !empty;
               top_in = s1_operand_ff;
               cnt_in = cnt_ff + CW'(1);
            end
         end
         FN_DUP: begin
            priority if (full) begin
               err = ERR_FULL;
            end else if (empty) begin
               err = ERR_EMPTY;
            end else begin
               wr_req = 1'b1;
               cnt_in = cnt_ff + CW'(1);
            end
         end
         FN_SWAP: begin
            if (cnt_ff < CW'(2)) begin
               err = ERR_FEW;
            end else begin
               wr_req  = 1'b1;
               wr_addr = cnt_m2[AW-1:0];
               top_in  = nos;
            end
         end
         FN_DISCARD: begin
            if (empty) begin
               err = ERR_EMPTY;
            end else begin
               top_in = nos;
               cnt_in = cnt_m1;
            end
         end
         FN_COPY: begin
            priority if (full) begin
               err = ERR_FULL;
            end else if (!copy_ok) begin
               err = ERR_INDEX;
            end else begin
               wr_req = 1'b1;
               // position equal to the depth names the top itself
               top_in = ($unsigned(s1_operand_ff) == DATA_W'(cnt_ff)) ? top_ff : cp_val;
               cnt_in = cnt_ff + CW'(1);
            end
         end
         FN_SLIDE: begin
            // the top stays put, only the depth shrinks
            priority if (empty) begin
               err = ERR_EMPTY;
            end else if (s1_operand_ff[DATA_W-1]) begin
               err = ERR_INDEX;
            end else if ($unsigned(s1_operand_ff) >= DATA_W'(cnt_m1)) begin
               cnt_in = CW'(1);
            end else begin
               cnt_in = cnt_ff - s1_operand_ff[CW-1:0];
            end
         end
         FN_POP: begin
            if (empty) begin
               err = ERR_EMPTY;
            end else begin
               popped = top_ff;
               top_in = nos;
               cnt_in = cnt_m1;
            end
         end
      endcase
   end

   assign mem_we = exec && wr_req;

   // keep the second entry of the next state prefetched
   always_comb begin
      if (exec) begin
         nos_addr = AW'(cnt_in - CW'(2));
      end else begin
         nos_addr = cnt_m2[AW-1:0];
      end
   end

   assign cp_addr = req_operand[AW-1:0] - AW'(1);

   // stack memory: one write, two registered reads
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      nos_rd_ff <= mem[nos_addr];
      if (req_accept) begin
         cp_rd_ff <= mem[cp_addr];
      end
   end

   // bypass registers
   always_ff @(posedge clock) begin
      nos_hit_ff <= mem_we && (wr_addr == nos_addr);
      wd_ff      <= wr_data;
      if (req_accept) begin
         cp_hit_ff <= mem_we && (wr_addr == cp_addr);
         cp_byp_ff <= wr_data;
      end
   end

   // request stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (exec) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_func_ff    <= func_type'(req_func);
         s1_operand_ff <= req_operand;
      end
   end

   // stack state
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (exec) begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         top_ff <= top_in;
      end
   end

   // response stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (exec) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         popped_ff <= popped;
         error_ff  <= err;
         depth_ff  <= cnt_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_popped = popped_ff;
   assign rsp_error  = error_ff;
   assign rsp_depth  = depth_ff;

`ifndef SYNTHESIS
   // depth never passes the capacity
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(DEPTH))
      else $error("stack depth beyond capacity");

   // a failing operation leaves the depth unchanged
   a_err_keeps_depth: assert property (@(posedge clock) disable iff (reset)
      exec && (err != ERR_OK) |=> cnt_ff == $past(cnt_ff))
      else $error("failing operation changed the depth");

   // a non-zero popped value only comes with a clean result
   a_popped_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (popped_ff != '0) |-> error_ff == ERR_OK)
      else $error("popped value reported with an error");

   // the request side only stalls while its stage holds a beat
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("request stalled without a held response");
`endif

endmodule

// ----- bench/data_stack_with_dup_swap_copy_slide_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// data_stack_with_dup_swap_copy_slide_tb
// self-checking bench for the data stack: a short table of hand-picked
// operations, then random bursts that steer the depth towards chosen targets
// (empty, shallow, anywhere, full), all checked beat by beat against fixed
// answers or a shadow stack kept inside the bench, under several idle and stall patterns
// ----------------------------------------------------------------------------
module data_stack_with_dup_swap_copy_slide_tb;
   import dstk_pkg::*;

   localparam int CNT_W          = $clog2(STK_DEPTH + 1);
   localparam int DIR_ROWS       = 26;
   localparam int PHASE_BEATS    = 450;
   localparam int HOLD_BEATS     = 24;
   localparam int HOLD_CYCLES    = 60;
   localparam int WATCHDOG_LIMIT = 2000;

   // one response beat as the bench expects it
   typedef struct packed {
      logic [DATA_W-1:0] popped;
      err_type           err;
      logic [CNT_W-1:0]  depth;
   } stack_result_type;

   // one row of the directed table; fixed rows carry their own answer
   typedef struct packed {
      func_type          fn;
      logic [DATA_W-1:0] opnd;
      bit                fixed;
      stack_result_type  res;
   } dir_row_type;

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_valid   = 1'b0;
   logic                     req_stall;
   logic [2:0]               req_func    = FN_CLEAR;
   logic signed [DATA_W-1:0] req_operand = '0;
   logic                     rsp_valid;
   logic                     rsp_stall   = 1'b0;
   logic signed [DATA_W-1:0] rsp_popped;
   logic [2:0]               rsp_error;
   logic [CNT_W-1:0]         rsp_depth;

   // shadow copy of the stack contents and depth
   logic [DATA_W-1:0] shadow_words [STK_DEPTH];
   int                shadow_count = 0;

   stack_result_type pending_results [$];
   stack_result_type front_exp;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   bit hold_request  = 1'b0;
   int hold_left     = 0;
   int quiet_cycles  = 0;
   int mismatches    = 0;
   int req_beats     = 0;
   int rsp_beats     = 0;
   int deepest       = 0;
   int func_seen [8];
   int err_seen [8];

   always #4 clock = ~clock;

   data_stack_with_dup_swap_copy_slide uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_func    (req_func),
      .req_operand (req_operand),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_popped  (rsp_popped),
      .rsp_error   (rsp_error),
      .rsp_depth   (rsp_depth)
   );

   // applies one operation to the shadow stack and returns its answer;
   // a failing operation leaves the shadow untouched
   function automatic stack_result_type next_stack_result(func_type fn,
                                                          logic [DATA_W-1:0] opnd);
      stack_result_type  res;
      longint            pos;
      logic [DATA_W-1:0] tmp;
      res.popped = '0;
      res.err    = ERR_OK;
      pos        = longint'($signed(opnd));
      case (fn)
         FN_CLEAR: shadow_count = 0;
         FN_PUSH: begin
            if (shadow_count >= STK_DEPTH) res.err = ERR_FULL;
            else begin
               shadow_words[shadow_count] = opnd;
               shadow_count++;
            end
         end
         FN_DUP: begin
            // full wins over empty
            if (shadow_count >= STK_DEPTH) res.err = ERR_FULL;
            else if (shadow_count == 0) res.err = ERR_EMPTY;
            else begin
               shadow_words[shadow_count] = shadow_words[shadow_count - 1];
               shadow_count++;
            end
         end
         FN_SWAP: begin
            if (shadow_count < 2) res.err = ERR_FEW;
            else begin
               tmp = shadow_words[shadow_count - 1];
               shadow_words[shadow_count - 1] = shadow_words[shadow_count - 2];
               shadow_words[shadow_count - 2] = tmp;
            end
         end
         FN_DISCARD: begin
            if (shadow_count == 0) res.err = ERR_EMPTY;
            else shadow_count--;
         end
         FN_COPY: begin
            // full wins over a bad position; positions count from 1 at the bottom
            if (shadow_count >= STK_DEPTH) res.err = ERR_FULL;
            else if (pos < 1 || pos > shadow_count) res.err = ERR_INDEX;
            else begin
               shadow_words[shadow_count] = shadow_words[pos - 1];
               shadow_count++;
            end
         end
         FN_SLIDE: begin
            // empty wins over a negative count
            if (shadow_count == 0) res.err = ERR_EMPTY;
            else if (pos < 0) res.err = ERR_INDEX;
            else if (pos >= shadow_count - 1) begin
               shadow_words[0] = shadow_words[shadow_count - 1];
               shadow_count = 1;
            end else begin
               shadow_words[shadow_count - 1 - int'(pos)] = shadow_words[shadow_count - 1];
               shadow_count -= int'(pos);
            end
         end
         FN_POP: begin
            if (shadow_count == 0) res.err = ERR_EMPTY;
            else begin
               shadow_count--;
               res.popped = shadow_words[shadow_count];
            end
         end
      endcase
      res.depth = shadow_count[CNT_W-1:0];
      return res;
   endfunction

   // offers one request beat and waits for it to be taken; valid is only
   // lowered when an idle gap follows, so back-to-back beats keep it high
   task automatic send_beat(input func_type fn, input logic [DATA_W-1:0] opnd,
                            input bit fixed, input stack_result_type fixed_res);
      stack_result_type res;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid   <= 1'b1;
      req_func    <= fn;
      req_operand <= opnd;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      res = next_stack_result(fn, opnd);
      pending_results.push_back(fixed ? fixed_res : res);
      func_seen[int'(fn)]++;
      req_beats++;
   endtask

   // sender goes quiet until every outstanding response has come back
   task automatic drain_responses();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // chooses the next operation so that the depth drifts towards target,
   // with a little noise; operands mostly land in range
   task automatic pick_beat(input int target, output func_type fn,
                            output logic [DATA_W-1:0] opnd);
      int r;
      r    = $urandom_range(99);
      opnd = $urandom;
      if (r < 5) begin
         fn = func_type'($urandom_range(7, 0));
         if (fn == FN_CLEAR && target > 16) fn = FN_SWAP;
      end else if (shadow_count < target) begin
         r  = $urandom_range(9);
         fn = (r < 6) ? FN_PUSH : (r < 8) ? FN_DUP : FN_COPY;
      end else if (shadow_count > target) begin
         r  = $urandom_range(9);
         fn = (r < 5) ? FN_POP : (r < 8) ? FN_DISCARD :
              (r == 9 && target == 0) ? FN_CLEAR : FN_SLIDE;
      end else begin
         // holding at the target: anything but clear
         fn = func_type'($urandom_range(7, 1));
      end
      case (fn)
         FN_PUSH: begin
            case ($urandom_range(7))
               0: opnd = 32'h8000_0000;
               1: opnd = 32'h7fff_ffff;
               2: opnd = '0;
               3: opnd = '1;
               default: ;
            endcase
         end
         FN_COPY: begin
            case ($urandom_range(7))
               0: opnd = '0;
               1: opnd = shadow_count + 1;
               2: opnd = 32'hffff_ffff - $urandom_range(3);
               3: ;   // raw word, almost surely out of range
               default: if (shadow_count > 0) opnd = $urandom_range(shadow_count, 1);
            endcase
         end
         FN_SLIDE: begin
            case ($urandom_range(9))
               6, 7: begin
                  if (shadow_count <= 16) opnd = $urandom_range(shadow_count + 1, 0);
                  else opnd = $urandom_range(3);
               end
               8: opnd = 32'hffff_ffff - $urandom_range(3);
               9: if (target >= 64) opnd = $urandom_range(3);  // else keep raw word
               default: opnd = $urandom_range(3);
            endcase
         end
         default: ;
      endcase
   endtask

   // response side: check each accepted beat, then decide the next stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_beats++;
         err_seen[rsp_error]++;
         if (int'(rsp_depth) > deepest) deepest = rsp_depth;
         if (pending_results.size() == 0) begin
            $display("%0t: response beat with nothing outstanding", $time);
            $display("   popped %h error %0d depth %0d", rsp_popped, rsp_error, rsp_depth);
            mismatches++;
         end else begin
            front_exp = pending_results.pop_front();
            if (rsp_popped !== front_exp.popped) begin
               $display("%0t: popped mismatch, expected %h got %h",
                        $time, front_exp.popped, rsp_popped);
               mismatches++;
            end
            if (rsp_error !== front_exp.err) begin
               $display("%0t: error code mismatch, expected %0d got %0d",
                        $time, front_exp.err, rsp_error);
               mismatches++;
            end
            if (rsp_depth !== front_exp.depth) begin
               $display("%0t: depth mismatch, expected %0d got %0d",
                        $time, front_exp.depth, rsp_depth);
               mismatches++;
            end
         end
      end
      // long hold-off, counted here so the sender keeps pushing meanwhile
      if (hold_request) begin
         hold_left    = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // watchdog: too long without any beat on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no beat for %0d cycles, %0d responses outstanding",
                     $time, quiet_cycles, pending_results.size());
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin
      dir_row_type      dir_rows [DIR_ROWS];
      stack_result_type no_res;
      func_type         fn;
      logic [31:0]      opnd;
      int               target;
      int               burst_len;
      int               phase_beats;
      int               r;
      int               fewest;

      no_res = '{32'd0, ERR_OK, 0};
      // hand-picked rows: everything on an empty stack, bad positions and
      // counts, operand extremes, then a short mix checked by the shadow
      dir_rows = '{
         '{FN_POP,     32'h0000_0000, 1'b1, '{32'd0, ERR_EMPTY, 0}},
         '{FN_DISCARD, 32'h0000_0000, 1'b1, '{32'd0, ERR_EMPTY, 0}},
         '{FN_DUP,     32'h0000_0000, 1'b1, '{32'd0, ERR_EMPTY, 0}},
         '{FN_SWAP,    32'h0000_0000, 1'b1, '{32'd0, ERR_FEW,   0}},
         '{FN_SLIDE,   32'h0000_0000, 1'b1, '{32'd0, ERR_EMPTY, 0}},
         '{FN_SLIDE,   32'h8000_0000, 1'b1, '{32'd0, ERR_EMPTY, 0}},
         '{FN_COPY,    32'h0000_0001, 1'b1, '{32'd0, ERR_INDEX, 0}},
         '{FN_PUSH,    32'h7fff_ffff, 1'b1, '{32'd0, ERR_OK,    1}},
         '{FN_SWAP,    32'h0000_0000, 1'b1, '{32'd0, ERR_FEW,   1}},
         '{FN_COPY,    32'h0000_0000, 1'b1, '{32'd0, ERR_INDEX, 1}},
         '{FN_COPY,    32'hffff_ffff, 1'b1, '{32'd0, ERR_INDEX, 1}},
         '{FN_COPY,    32'h0000_0002, 1'b1, '{32'd0, ERR_INDEX, 1}},
         '{FN_COPY,    32'h8000_0000, 1'b1, '{32'd0, ERR_INDEX, 1}},
         '{FN_PUSH,    32'h8000_0000, 1'b1, '{32'd0, ERR_OK,    2}},
         '{FN_PUSH,    32'hffff_ffff, 1'b1, '{32'd0, ERR_OK,    3}},
         '{FN_PUSH,    32'h0000_0000, 1'b1, '{32'd0, ERR_OK,    4}},
         '{FN_COPY,    32'h0000_0001, 1'b0, no_res},
         '{FN_SWAP,    32'h0000_0000, 1'b0, no_res},
         '{FN_DUP,     32'h0000_0000, 1'b0, no_res},
         '{FN_SLIDE,   32'hffff_ffff, 1'b1, '{32'd0, ERR_INDEX, 6}},
         '{FN_SLIDE,   32'h0000_0000, 1'b0, no_res},
         '{FN_SLIDE,   32'h0000_0002, 1'b0, no_res},
         '{FN_POP,     32'h0000_0000, 1'b0, no_res},
         '{FN_SLIDE,   32'h7fff_ffff, 1'b1, '{32'd0, ERR_OK,    1}},
         '{FN_POP,     32'h0000_0000, 1'b0, no_res},
         '{FN_CLEAR,   32'h0000_0000, 1'b1, '{32'd0, ERR_OK,    0}}
      };

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++)
         send_beat(dir_rows[i].fn, dir_rows[i].opnd, dir_rows[i].fixed, dir_rows[i].res);
      drain_responses();

      // random bursts under four idle patterns: none, sender idle,
      // receiver stalling, both lightly
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 85; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 85; end
            default: begin send_idle_pct = 6; rsp_stall_pct = 6; end
         endcase
         phase_beats = 0;
         while (phase_beats < PHASE_BEATS) begin
            r = $urandom_range(99);
            // even phases open by filling the stack to the top
            if ((phase_beats == 0 && ph % 2 == 0) || r < 12) begin
               target = STK_DEPTH;  burst_len = 400;
            end else if (r < 27) begin
               target = 0;          burst_len = 20;
            end else if (r < 67) begin
               target = $urandom_range(12, 1);  burst_len = 30;
            end else begin
               target = $urandom_range(STK_DEPTH, 1);  burst_len = 150;
            end
            for (int k = 0; k < burst_len && phase_beats < PHASE_BEATS; k++) begin
               pick_beat(target, fn, opnd);
               send_beat(fn, opnd, 1'b0, no_res);
               phase_beats++;
            end
         end
         drain_responses();

         // after the first phase: receiver holds off for a long stretch
         // while requests keep coming, so the pipeline backs up
         if (ph == 0) begin
            hold_request = 1'b1;
            for (int k = 0; k < HOLD_BEATS; k++) begin
               pick_beat($urandom_range(20, 4), fn, opnd);
               send_beat(fn, opnd, 1'b0, no_res);
            end
            drain_responses();
         end
      end

      // a short tail catches any stray beat
      repeat (4) @(posedge clock);

      fewest = func_seen[0];
      foreach (func_seen[i]) if (func_seen[i] < fewest) fewest = func_seen[i];
      $display("run covered %0d request and %0d response beats, each operation %0d+ times",
               req_beats, rsp_beats, fewest);
      $display("deepest stack %0d of %0d; error codes: full %0d, empty %0d, few %0d, index %0d",
               deepest, STK_DEPTH, err_seen[ERR_FULL], err_seen[ERR_EMPTY],
               err_seen[ERR_FEW], err_seen[ERR_INDEX]);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches, %0d responses never arrived", mismatches,
                  pending_results.size());
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/dstk_pkg.sv
hw/rtl/data_stack_with_dup_swap_copy_slide.sv
bench/data_stack_with_dup_swap_copy_slide_tb.sv
